/* hdl/mexp_pkg.sv */
package mexp_pkg;

   // Widths of the transaction fields at the ports
   localparam int BASE_W = 31;
   localparam int EXP_W  = 63;
   localparam int MOD_W  = 31;
   localparam int OUT_W  = 31;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_REDUCE = 4'b0010,
      ST_POWER  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // Status of one bit-serial modular multiplier
   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

endpackage

/* hdl/mexp_mulmod.sv */
// Bit-serial interleaved modular multiplier: result = op_a * op_b mod modulus.
// op_a is consumed one bit per cycle, most significant first; op_b must be
// below modulus and modulus must be held stable and nonzero while busy.
module mexp_mulmod #(
   parameter int MOD_BITS = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [MOD_BITS-1:0]    op_a,
   input  logic [MOD_BITS-1:0]    op_b,
   input  logic [MOD_BITS-1:0]    modulus,
   output mexp_pkg::mm_status_type status,
   output logic [MOD_BITS-1:0]    result
);

   localparam int CNT_W = $clog2(MOD_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [MOD_BITS-1:0] a_ff, a_in;
   logic [MOD_BITS-1:0] b_ff, b_in;
   logic [MOD_BITS-1:0] r_ff, r_in;

   logic [MOD_BITS:0]   dbl;
   logic [MOD_BITS:0]   dbl_red;
   logic [MOD_BITS:0]   sum;
   logic [MOD_BITS:0]   sum_red;
   logic [MOD_BITS:0]   mod_ext;

   assign mod_ext = {1'b0, modulus};

   // One step: r = 2r + bit*b, kept below the modulus by two trial subtractions
   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
      sum     = dbl_red + (a_ff[MOD_BITS-1] ? {1'b0, b_ff} : '0);
      sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(MOD_BITS);
         a_in    = op_a;
         b_in    = op_b;
         r_in    = '0;
      end else if (busy_ff) begin
         r_in   = sum_red[MOD_BITS-1:0];
         a_in   = {a_ff[MOD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      r_ff   <= r_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result      = r_ff;

`ifndef ASSERT_OFF
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("multiplier restarted while busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("multiplier done while still busy");

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == CNT_W'(1)) |=> (r_ff < modulus))
      else $error("multiplier result not below modulus");
`endif

endmodule

/* hdl/modular_exponentiation_unit.sv */
// Channel | Dir | Ports                                          | Transfer
// req     | in  | req_valid/ready, req_base, req_exponent,      | valid && ready
//         |     | req_modulus                                    |
// rsp     | out | rsp_valid/ready, rsp_power_mod                 | valid && ready
//
// One transaction at a time. The work is done by the pair of bit-serial modular
// multipliers (one square, one multiply per exponent bit, up to the highest set
// bit). A zero exponent or zero modulus skips the multipliers and goes straight
// to ST_FINISH. Synchronous reset clears the sequencer and rsp_valid.
// A stalled rsp holds its result; the next transaction is accepted and computed,
// then holds in ST_FINISH, with req_ready low, until the result is taken.
module modular_exponentiation_unit #(
   parameter int EXP_BITS = 63,
   parameter int MOD_BITS = 31
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mexp_pkg::BASE_W-1:0]  req_base,
   input  logic [mexp_pkg::EXP_W-1:0]   req_exponent,
   input  logic [mexp_pkg::MOD_W-1:0]   req_modulus,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mexp_pkg::OUT_W-1:0]   rsp_power_mod
);

   mexp_pkg::state_type state_ff, state_in;

   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] bsq_ff, bsq_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [MOD_BITS-1:0] m_ff, m_in;
   logic [MOD_BITS-1:0] res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [mexp_pkg::OUT_W-1:0] rsp_data_ff, rsp_data_in;

   logic [MOD_BITS-1:0] req_b;
   logic [EXP_BITS-1:0] req_e;
   logic [MOD_BITS-1:0] req_m;
   logic [MOD_BITS-1:0] req_one;

   logic                start_a, start_b;
   logic [MOD_BITS-1:0] a_op_a, a_op_b;
   logic [MOD_BITS-1:0] a_res, b_res;
   mexp_pkg::mm_status_type a_stat, b_stat;

   assign req_b   = req_base[MOD_BITS-1:0];
   assign req_e   = req_exponent[EXP_BITS-1:0];
   assign req_m   = req_modulus[MOD_BITS-1:0];
   assign req_one = (req_m == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

   assign req_ready = (state_ff == mexp_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      bsq_in       = bsq_ff;
      exp_in       = exp_ff;
      m_in         = m_ff;
      res_in       = res_ff;
      start_a      = 1'b0;
      start_b      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (req_valid) begin
               m_in   = req_m;
               exp_in = req_e;
               acc_in = req_one;
               if (req_e == '0) begin
                  res_in   = MOD_BITS'(1);
                  state_in = mexp_pkg::ST_FINISH;
               end else if (req_m == '0) begin
                  res_in   = '0;
                  state_in = mexp_pkg::ST_FINISH;
               end else begin
                  // reduce the base as base * 1 mod m
                  start_a  = 1'b1;
                  state_in = mexp_pkg::ST_REDUCE;
               end
            end
         end
         mexp_pkg::ST_REDUCE: begin
            if (a_stat.done) begin
               bsq_in   = a_res;
               start_a  = 1'b1;
               start_b  = 1'b1;
               state_in = mexp_pkg::ST_POWER;
            end
         end
         mexp_pkg::ST_POWER: begin
            if (a_stat.done) begin
               if (exp_ff[0]) begin
                  acc_in = a_res;
               end
               bsq_in = b_res;
               exp_in = exp_ff >> 1;
               if (exp_in == '0) begin
                  res_in   = acc_in;
                  state_in = mexp_pkg::ST_FINISH;
               end else begin
                  start_a = 1'b1;
                  start_b = 1'b1;
               end
            end
         end
         mexp_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mexp_pkg::OUT_W'(res_ff);
               state_in     = mexp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase
   end

   // Unit A runs the base reduction, then acc * b; unit B runs b * b
   assign a_op_a = (state_ff == mexp_pkg::ST_IDLE) ? req_b   : acc_in;
   assign a_op_b = (state_ff == mexp_pkg::ST_IDLE) ? req_one : bsq_in;

   mexp_mulmod #(
      .MOD_BITS (MOD_BITS)
   ) u_mul_a (
      .clock   (clock),
      .reset   (reset),
      .start   (start_a),
      .op_a    (a_op_a),
      .op_b    (a_op_b),
      .modulus (m_ff),
      .status  (a_stat),
      .result  (a_res)
   );

   mexp_mulmod #(
      .MOD_BITS (MOD_BITS)
   ) u_mul_b (
      .clock   (clock),
      .reset   (reset),
      .start   (start_b),
      .op_a    (bsq_in),
      .op_b    (bsq_in),
      .modulus (m_ff),
      .status  (b_stat),
      .result  (b_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      bsq_ff      <= bsq_in;
      exp_ff      <= exp_in;
      m_ff        <= m_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_power_mod = rsp_data_ff;

`ifndef ASSERT_OFF
   a_units_in_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mexp_pkg::ST_POWER) |-> (a_stat.done == b_stat.done))
      else $error("square and multiply units out of step");

   a_power_exp_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mexp_pkg::ST_POWER) |-> (exp_ff != '0))
      else $error("power loop running with exhausted exponent");

   a_residues_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mexp_pkg::ST_POWER) |-> (acc_ff < m_ff && bsq_ff < m_ff))
      else $error("working residue not below modulus");

   a_units_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mexp_pkg::ST_IDLE || state_ff == mexp_pkg::ST_FINISH)
      |-> (!a_stat.busy && !b_stat.busy))
      else $error("multiplier busy outside the power loop");
`endif

endmodule
